@@ rtl/core/ttt_pkg.sv @@
// Shared types and constants for the timed tracking table.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package ttt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int KEY_W       = 56;
    localparam int WORD_W      = 32;
    localparam int CAT_W       = 2;
    localparam int CNT_W       = 7;
    localparam logic [WORD_W-1:0] STALE_RESET = 32'd280;

    localparam logic CMD_UPDATE   = 1'b0;
    localparam logic CMD_SNAPSHOT = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [KEY_W-1:0]  item_key;
        logic [CAT_W-1:0]  item_category;
        logic [WORD_W-1:0] coord_x;
        logic [WORD_W-1:0] coord_top;
        logic [WORD_W-1:0] coord_bottom;
        logic [WORD_W-1:0] time_now_ms;
        logic [CNT_W-1:0]  emit_limit;
    } t_in;

    typedef struct packed {
        logic              entry_valid;
        logic [WORD_W-1:0] out_x;
        logic [WORD_W-1:0] out_top;
        logic [WORD_W-1:0] out_lower;
        logic [CAT_W-1:0]  out_category;
        logic              last;
    } t_out;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [WORD_W-1:0] seen;
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] top;
        logic [WORD_W-1:0] bottom;
        logic [CAT_W-1:0]  cat;
    } t_slot;

    typedef struct packed {
        logic [KEY_W-1:0]  slot_key;
        logic [WORD_W-1:0] slot_time;
        logic [KEY_W-1:0]  item_key;
        logic [WORD_W-1:0] now;
        logic [WORD_W-1:0] limit;
        logic [WORD_W-1:0] ref_time;
    } t_cmp_req;

    typedef struct packed {
        logic match;
        logic empty;
        logic older;
        logic stale;
    } t_cmp_res;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_FIN
    } t_state;

endpackage

@@ rtl/core/ttt_store.sv @@
// Slot store: one memory row per slot with registered read, plus per-slot valid flags.
// The top level sees a slot whose flag is clear as key 0 and time 0. Depends on ttt_pkg.
`timescale 1ns / 1ps

module ttt_store (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr_en,
    input  logic [ttt_pkg::IDX_W-1:0]  i_wr_addr,
    input  ttt_pkg::t_slot             i_wr_data,
    input  logic                       i_rd_en,
    input  logic [ttt_pkg::IDX_W-1:0]  i_rd_addr,
    output ttt_pkg::t_slot             o_rd_data,
    input  logic                       i_clr_en,
    input  logic [ttt_pkg::IDX_W-1:0]  i_chk_addr,
    output logic                       o_chk_vld
);
    import ttt_pkg::*;

    t_slot                  r_mem [TABLE_DEPTH];
    t_slot                  r_rd;
    logic [TABLE_DEPTH-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end else if (i_clr_en) begin
            r_vld[i_chk_addr] <= 1'b0;
        end
    end

    assign o_rd_data = r_rd;
    assign o_chk_vld = r_vld[i_chk_addr];

endmodule

@@ rtl/core/ttt_cmp.sv @@
// Shared compare unit: key match, empty test, timestamp order and age check for one slot.
// Reused for every slot of a scan. Depends on ttt_pkg.
`timescale 1ns / 1ps

module ttt_cmp (
    input  ttt_pkg::t_cmp_req i_req,
    output ttt_pkg::t_cmp_res o_res
);
    import ttt_pkg::*;

    logic [WORD_W-1:0] age;

    always_comb begin
        age         = i_req.now - i_req.slot_time;
        o_res.match = (i_req.slot_key == i_req.item_key);
        o_res.empty = (i_req.slot_key == '0);
        o_res.older = (i_req.slot_time < i_req.ref_time);
        o_res.stale = (age > i_req.limit);
    end

endmodule

@@ rtl/core/timed_tracking_table.sv @@
// Top level of the timed tracking table: sequencer, output and hold registers, limit register.
// Instantiates ttt_store and ttt_cmp; depends on ttt_pkg.
//
//   channel  direction  handshake               payload
//   in       sink       i_in_valid / o_in_stall  i_in_data  (t_in)
//   out      source     o_out_valid / i_out_stall o_out_data (t_out)
//   cfg      sink       i_cfg_valid / o_cfg_ready i_cfg_data (stale limit)
//
// An item scans the slots in order, TABLE_DEPTH at most, then writes the slot or flushes the
// result: the registered-read slot memory and the shared compare unit handle one slot a cycle,
// while no output stall holds the scan. Update: the scan ends early on a key match.
// Snapshot: the scan ends at the last slot or once emit_limit entries are found.
// Synchronous active-low reset clears all slots at once and loads the limit with 280.
`timescale 1ns / 1ps

module timed_tracking_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  ttt_pkg::t_in               i_in_data,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    output ttt_pkg::t_out              o_out_data,
    input  logic                       i_out_stall,
    input  logic                       i_cfg_valid,
    input  logic [ttt_pkg::WORD_W-1:0] i_cfg_data,
    output logic                       o_cfg_ready
);
    import ttt_pkg::*;

    t_state            r_state, n_state;
    t_in               r_item;
    logic [IDX_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_cnt;
    logic [WORD_W-1:0] r_stale;
    logic              r_out_vld;
    t_out              r_out;
    logic              r_pend_vld;
    t_out              r_pend;
    logic              r_have_free;
    logic [IDX_W-1:0]  r_free_idx;
    logic [IDX_W-1:0]  r_old_idx;
    logic [WORD_W-1:0] r_old_time;
    logic [IDX_W-1:0]  r_tgt;

    logic              in_acc;
    logic              out_free;
    logic              slot_vld;
    t_slot             rd_data;
    t_cmp_req          cmp_req;
    t_cmp_res          cmp_res;
    logic              last_slot;
    logic              is_snap;
    logic              live_fresh;
    logic              hold;
    logic              emit;
    logic              cnt_hit;
    logic              advance;
    logic              n_have_free;
    logic [IDX_W-1:0]  n_free_idx;
    logic [IDX_W-1:0]  n_old_idx;
    logic [WORD_W-1:0] n_old_time;
    logic              take_old;
    t_out              entry;
    t_out              empty_last;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    t_slot             wr_data;
    logic              clr_en;
    logic              out_load;
    t_out              out_next;

    ttt_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_addr  (r_tgt),
        .i_wr_data  (wr_data),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_rd_data  (rd_data),
        .i_clr_en   (clr_en),
        .i_chk_addr (r_idx),
        .o_chk_vld  (slot_vld)
    );

    ttt_cmp u_cmp (
        .i_req (cmp_req),
        .o_res (cmp_res)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_vld || !i_out_stall;

    always_comb begin
        cmp_req.slot_key  = slot_vld ? rd_data.key : '0;
        cmp_req.slot_time = slot_vld ? rd_data.seen : '0;
        cmp_req.item_key  = r_item.item_key;
        cmp_req.now       = r_item.time_now_ms;
        cmp_req.limit     = r_stale;
        cmp_req.ref_time  = r_old_time;
    end

    always_comb begin
        last_slot  = (r_idx == IDX_W'(TABLE_DEPTH - 1));
        is_snap    = (r_item.cmd == CMD_SNAPSHOT);
        live_fresh = is_snap && !cmp_res.empty && !cmp_res.stale;
        hold       = live_fresh && r_pend_vld && !out_free;
        emit       = live_fresh && !hold;
        cnt_hit    = ((r_cnt + 1'b1) == r_item.emit_limit);
        if (is_snap) begin
            advance = !hold && !(emit && cnt_hit);
        end else begin
            advance = !cmp_res.match;
        end

        take_old    = (r_idx == '0) || cmp_res.older;
        n_have_free = r_have_free || cmp_res.empty;
        n_free_idx  = (cmp_res.empty && !r_have_free) ? r_idx : r_free_idx;
        n_old_idx   = take_old ? r_idx : r_old_idx;
        n_old_time  = take_old ? cmp_req.slot_time : r_old_time;

        entry.entry_valid  = 1'b1;
        entry.out_x        = rd_data.x;
        entry.out_top      = rd_data.top;
        entry.out_lower    = rd_data.bottom;
        entry.out_category = rd_data.cat;
        entry.last         = 1'b0;
        empty_last         = '0;
        empty_last.last    = 1'b1;

        wr_data.key    = r_item.item_key;
        wr_data.seen   = r_item.time_now_ms;
        wr_data.x      = r_item.coord_x;
        wr_data.top    = r_item.coord_top;
        wr_data.bottom = r_item.coord_bottom;
        wr_data.cat    = r_item.item_category;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.cmd == CMD_SNAPSHOT && i_in_data.emit_limit == '0) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (is_snap) begin
                    if (emit && cnt_hit) begin
                        n_state = S_FIN;
                    end else if (advance && last_slot) begin
                        n_state = S_FIN;
                    end
                end else if (cmp_res.match || last_slot) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        rd_en    = 1'b0;
        rd_addr  = r_idx + 1'b1;
        wr_en    = 1'b0;
        clr_en   = 1'b0;
        out_load = 1'b0;
        out_next = empty_last;
        case (r_state)
            S_IDLE: begin
                rd_en   = in_acc;
                rd_addr = '0;
            end
            S_SCAN: begin
                rd_en  = advance && !last_slot && n_state == S_SCAN;
                clr_en = is_snap && !cmp_res.empty && cmp_res.stale;
                if (emit && r_pend_vld) begin
                    out_load = 1'b1;
                    out_next = r_pend;
                end
            end
            S_WRITE: begin
                wr_en    = out_free;
                out_load = out_free;
            end
            S_FIN: begin
                out_load = out_free;
                if (r_pend_vld) begin
                    out_next      = r_pend;
                    out_next.last = 1'b1;
                end
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_stale    <= STALE_RESET;
            r_out_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_stale <= i_cfg_data;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (r_state == S_SCAN && emit) begin
                r_pend_vld <= 1'b1;
            end else if (r_state == S_FIN && out_free) begin
                r_pend_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= out_next;
        end
        if (in_acc) begin
            r_item      <= i_in_data;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_have_free <= 1'b0;
            r_free_idx  <= '0;
            r_old_idx   <= '0;
            r_old_time  <= '0;
        end else if (r_state == S_SCAN) begin
            r_have_free <= n_have_free;
            r_free_idx  <= n_free_idx;
            r_old_idx   <= n_old_idx;
            r_old_time  <= n_old_time;
            if (advance && !last_slot) begin
                r_idx <= r_idx + 1'b1;
            end
            if (emit) begin
                r_pend <= entry;
                r_cnt  <= r_cnt + 1'b1;
            end
            if (!is_snap) begin
                if (cmp_res.match) begin
                    r_tgt <= r_idx;
                end else begin
                    r_tgt <= n_have_free ? n_free_idx : n_old_idx;
                end
            end
        end
    end

endmodule

@@ rtl/core/ttt_checker.sv @@
// Port-level checker for the timed tracking table, bound to the top level.
// Sees only the top-level ports; depends on ttt_pkg.
`timescale 1ns / 1ps

module ttt_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input ttt_pkg::t_out o_out_data,
    input logic          i_out_stall
);
    import ttt_pkg::*;

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.entry_valid) |-> o_out_data.last)
        else $error("result without entry is not last");

    a_empty_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.entry_valid) |->
            (o_out_data.out_category == '0 && o_out_data.out_x == '0 &&
             o_out_data.out_top == '0 && o_out_data.out_lower == '0))
        else $error("result without entry carries data");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again without a scan");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled transaction changed");

endmodule

bind timed_tracking_table ttt_checker u_ttt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

@@ sim/testbench.sv @@
// Self-checking testbench for timed_tracking_table: directed and random updates and snapshots
// with bursty input, patterned output stalls and stale-limit changes between phases.
// Depends on ttt_pkg and the timed_tracking_table RTL only.
`timescale 1ns / 1ps

module testbench;
    import ttt_pkg::*;

    localparam int KEY_POOL       = 96;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_OFF       = 400;
    localparam int MAX_REPORTS    = 10;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_HEAVY,
        STALL_ALTERNATE
    } t_stall_mode;

    class tracking_table_model;
        logic [KEY_W-1:0]  slot_key [TABLE_DEPTH];
        logic [WORD_W-1:0] seen_ms  [TABLE_DEPTH];
        logic [WORD_W-1:0] slot_x   [TABLE_DEPTH];
        logic [WORD_W-1:0] slot_top [TABLE_DEPTH];
        logic [WORD_W-1:0] slot_bot [TABLE_DEPTH];
        logic [CAT_W-1:0]  slot_cat [TABLE_DEPTH];
        logic [WORD_W-1:0] stale_limit;
        t_out              pending_results[$];
        int unsigned       mismatches;
        int unsigned       results_checked;

        function new();
            stale_limit = STALE_RESET;
            mismatches = 0;
            results_checked = 0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                clear_slot(i);
            end
        endfunction

        function void clear_slot(input int i);
            slot_key[i] = '0;
            seen_ms[i]  = '0;
            slot_x[i]   = '0;
            slot_top[i] = '0;
            slot_bot[i] = '0;
            slot_cat[i] = '0;
        endfunction

        function void refresh_or_insert(input t_in item);
            int target;
            int open_slot;
            int oldest;
            t_out done;
            target = -1;
            open_slot = -1;
            oldest = 0;
            for (int i = 0; i < TABLE_DEPTH && target < 0; i++) begin
                if (slot_key[i] == item.item_key) begin
                    target = i;
                end else begin
                    if (slot_key[i] == '0 && open_slot < 0) open_slot = i;
                    if (seen_ms[i] < seen_ms[oldest]) oldest = i;
                end
            end
            if (target < 0) target = (open_slot >= 0) ? open_slot : oldest;
            slot_key[target] = item.item_key;
            seen_ms[target]  = item.time_now_ms;
            slot_x[target]   = item.coord_x;
            slot_top[target] = item.coord_top;
            slot_bot[target] = item.coord_bottom;
            slot_cat[target] = item.item_category;
            done = '0;
            done.last = 1'b1;
            pending_results.push_back(done);
        endfunction

        function void snapshot_live(input t_in item);
            int emitted;
            logic [WORD_W-1:0] age;
            t_out entry;
            emitted = 0;
            for (int i = 0; i < TABLE_DEPTH && emitted < int'(item.emit_limit); i++) begin
                if (slot_key[i] != '0) begin
                    age = item.time_now_ms - seen_ms[i];
                    if (age > stale_limit) begin
                        clear_slot(i);
                    end else begin
                        entry = '0;
                        entry.entry_valid  = 1'b1;
                        entry.out_x        = slot_x[i];
                        entry.out_top      = slot_top[i];
                        entry.out_lower    = slot_bot[i];
                        entry.out_category = slot_cat[i];
                        pending_results.push_back(entry);
                        emitted++;
                    end
                end
            end
            if (emitted == 0) begin
                entry = '0;
                entry.last = 1'b1;
                pending_results.push_back(entry);
            end else begin
                pending_results[pending_results.size() - 1].last = 1'b1;
            end
        endfunction

        function void note_item(input t_in item);
            if (item.cmd == CMD_UPDATE) refresh_or_insert(item);
            else snapshot_live(item);
        endfunction

        function void check_result(input t_out got);
            t_out want;
            results_checked++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"result %0d unexpected: valid=%0b x=%h top=%h bottom=%h",
                              " cat=%0d last=%0b"},
                             results_checked, got.entry_valid, got.out_x, got.out_top,
                             got.out_lower, got.out_category, got.last);
                return;
            end
            want = pending_results.pop_front();
            if (got.entry_valid !== want.entry_valid || got.out_x !== want.out_x ||
                got.out_top !== want.out_top || got.out_lower !== want.out_lower ||
                got.out_category !== want.out_category || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display({"result %0d expected: valid=%0b x=%h top=%h bottom=%h",
                              " cat=%0d last=%0b"},
                             results_checked, want.entry_valid, want.out_x, want.out_top,
                             want.out_lower, want.out_category, want.last);
                    $display({"result %0d actual:   valid=%0b x=%h top=%h bottom=%h",
                              " cat=%0d last=%0b"},
                             results_checked, got.entry_valid, got.out_x, got.out_top,
                             got.out_lower, got.out_category, got.last);
                end
            end
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    t_in               in_data    = '0;
    logic              in_stall;
    logic              out_valid;
    t_out              out_data;
    logic              out_stall  = 1'b0;
    logic              cfg_valid  = 1'b0;
    logic [WORD_W-1:0] cfg_data   = '0;
    logic              cfg_ready;

    tracking_table_model board = new();

    logic [KEY_W-1:0]  key_pool[KEY_POOL];
    logic [WORD_W-1:0] cur_ms      = '0;
    int                burst_left  = 4;
    int                results_seen = 0;
    int                hold_left   = 0;
    int                mode_left   = 0;
    t_stall_mode       stall_mode  = STALL_NONE;
    logic              alt_phase   = 1'b0;
    int                idle_cycles = 0;

    timed_tracking_table dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .i_cfg_data  (cfg_data),
        .o_cfg_ready (cfg_ready)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        logic stall_next;
        if (rst_n && out_valid && !out_stall) begin
            board.check_result(out_data);
            results_seen++;
            if (results_seen == 200 || results_seen == 1500) hold_left = HOLD_OFF;
        end
        if (mode_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 120);
        end else begin
            mode_left--;
        end
        alt_phase = ~alt_phase;
        if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
        end else begin
            case (stall_mode)
                STALL_NONE:      stall_next = 1'b0;
                STALL_RANDOM:    stall_next = 1'($urandom_range(0, 1));
                STALL_HEAVY:     stall_next = ($urandom_range(0, 3) != 0);
                default:         stall_next = alt_phase;
            endcase
        end
        out_stall <= stall_next;
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
    end

    function automatic t_in make_update(input logic [KEY_W-1:0] key, input logic [CAT_W-1:0] cat,
                                        input logic [WORD_W-1:0] x, input logic [WORD_W-1:0] top,
                                        input logic [WORD_W-1:0] bottom,
                                        input logic [WORD_W-1:0] now);
        t_in item;
        item.cmd           = CMD_UPDATE;
        item.item_key      = key;
        item.item_category = cat;
        item.coord_x       = x;
        item.coord_top     = top;
        item.coord_bottom  = bottom;
        item.time_now_ms   = now;
        item.emit_limit    = 7'($urandom);
        return item;
    endfunction

    function automatic t_in make_snapshot(input logic [CNT_W-1:0] count,
                                          input logic [WORD_W-1:0] now);
        t_in item;
        item.cmd           = CMD_SNAPSHOT;
        item.item_key      = {24'($urandom), $urandom};
        item.item_category = 2'($urandom);
        item.coord_x       = $urandom;
        item.coord_top     = $urandom;
        item.coord_bottom  = $urandom;
        item.time_now_ms   = now;
        item.emit_limit    = count;
        return item;
    endfunction

    function automatic t_in random_item(input int unsigned max_step);
        t_in item;
        int unsigned pick;
        logic [KEY_W-1:0] key;
        logic [CAT_W-1:0] cat;
        logic [CNT_W-1:0] count;
        if ($urandom_range(0, 99) < 2) cur_ms = $urandom;
        else cur_ms = cur_ms + $urandom_range(0, max_step);
        pick = $urandom_range(0, 99);
        if (pick < 84) key = key_pool[$urandom_range(0, KEY_POOL - 1)];
        else if (pick < 96) key = {24'($urandom), $urandom};
        else if (pick < 98) key = '0;
        else key = '1;
        cat = ($urandom_range(0, 15) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
        pick = $urandom_range(0, 99);
        if (pick < 30) count = 7'($urandom_range(0, 127));
        else if (pick < 70) count = 7'($urandom_range(48, 64));
        else count = 7'($urandom_range(1, 16));
        if ($urandom_range(0, 99) < 80)
            item = make_update(key, cat, $urandom, $urandom, $urandom, cur_ms);
        else
            item = make_snapshot(count, cur_ms);
        return item;
    endfunction

    task automatic send_item(input t_in item);
        int gap;
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_item(item);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge clk);
        repeat (TABLE_DEPTH + 8) @(posedge clk);
    endtask

    task automatic write_stale_limit(input logic [WORD_W-1:0] limit_ms);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= limit_ms;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.stale_limit = limit_ms;
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int n_items, input int unsigned max_step);
        for (int n = 0; n < n_items; n++) send_item(random_item(max_step));
    endtask

    initial begin
        for (int i = 0; i < KEY_POOL; i++) key_pool[i] = {24'($urandom), $urandom};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, extremes, key zero, category zero, refresh
        send_item(make_snapshot(7'd64, 32'd100));
        send_item(make_update('1, 2'd3, '1, '1, '1, 32'd100));
        send_item(make_update(56'd1, 2'd1, '0, '0, '0, 32'd100));
        send_item(make_update('0, 2'd2, $urandom, $urandom, $urandom, 32'd100));
        send_item(make_update(key_pool[0], 2'd0, $urandom, $urandom, $urandom, 32'd120));
        send_item(make_update(56'd1, 2'd2, $urandom, $urandom, $urandom, 32'd150));
        // count limits, then age exactly at and just beyond the limit
        send_item(make_snapshot(7'd0, 32'd150));
        send_item(make_snapshot(7'd1, 32'd150));
        send_item(make_snapshot(7'd127, 32'd150));
        send_item(make_snapshot(7'd64, 32'd380));
        send_item(make_snapshot(7'd64, 32'd381));
        // wrap of the millisecond counter
        send_item(make_update(key_pool[1], 2'd1, $urandom, $urandom, $urandom, 32'hFFFF_FFF0));
        send_item(make_update(key_pool[2], 2'd3, $urandom, $urandom, $urandom, 32'hFFFF_FFFF));
        send_item(make_snapshot(7'd64, 32'h0000_0010));
        send_item(make_update(key_pool[3], 2'd1, $urandom, $urandom, $urandom, 32'h0000_0100));
        send_item(make_update(key_pool[4], 2'd2, $urandom, $urandom, $urandom, 32'h0000_0100));
        // one-entry limit with every slot stale, then an empty table and a single entry
        send_item(make_snapshot(7'd1, 32'h0000_0300));
        send_item(make_snapshot(7'd127, 32'h0000_0000));
        send_item(make_update('1, 2'd3, '0, '1, '0, 32'h0000_0000));
        send_item(make_snapshot(7'd64, 32'h0000_0000));
        cur_ms = 32'd0;

        run_random(60, 40);

        write_stale_limit('0);
        run_random(80, 2);

        write_stale_limit('1);
        cur_ms = 32'hFFFF_F000;
        run_random(130, 200);

        write_stale_limit(32'($urandom_range(100, 600)));
        run_random(120, 60);

        write_stale_limit(32'($urandom_range(1, 50)));
        run_random(100, 8);

        drain();
        if (board.mismatches == 0 && board.outstanding() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/ttt_pkg.sv
rtl/core/ttt_store.sv
rtl/core/ttt_cmp.sv
rtl/core/timed_tracking_table.sv
rtl/core/ttt_checker.sv
sim/testbench.sv
